[rtl/core/base64_stream_decoder_core_macros.svh]
// ============================================================================
// base64_stream_decoder_core_macros.svh
// Assertion macros shared by the decoder's checker.
// ============================================================================
`ifndef BASE64_STREAM_DECODER_CORE_MACROS_SVH
`define BASE64_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define B64D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also checks the reset itself.
`define B64D_ASSERT_RESET(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/b64d_pkg.sv]
// ============================================================================
// b64d_pkg
// Types, character codes and the alphabet lookup of the base64 decoder.
// ============================================================================
package b64d_pkg;

    // Character codes of the standard alphabet
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PAD   = 8'h3D;

    // Sextet values that do not come from a letter offset
    localparam logic [5:0] SX_LO_BASE = 6'd26;
    localparam logic [5:0] SX_DIG_BASE = 6'd52;
    localparam logic [5:0] SX_PLUS = 6'd62;
    localparam logic [5:0] SX_SLASH = 6'd63;

    // Byte counts of a bundle
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE = 2'd1;
    localparam logic [1:0] CNT_TWO = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] code_char;
        logic       final_char;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       run_last;
        logic       string_end;
    } t_out_word;

    // Decoded character
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sextet;

    // Bytes caused by one character, oldest in byte0
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] cnt;
        logic       string_end;
    } t_bundle;

    // Front-to-queue write
    typedef struct packed {
        logic    valid;
        t_bundle bundle;
    } t_q_write;

    // Map one character to its sextet; ok is low outside the alphabet
    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet s;
        s.ok  = 1'b1;
        s.val = '0;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            s.val = 6'(c - CH_UP_A);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            s.val = 6'(c - CH_LO_A) + SX_LO_BASE;
        end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
            s.val = 6'(c - CH_DIG_0) + SX_DIG_BASE;
        end else if (c == CH_PLUS) begin
            s.val = SX_PLUS;
        end else if (c == CH_SLASH) begin
            s.val = SX_SLASH;
        end else begin
            s.ok = 1'b0;
        end
        if (c == CH_PAD) begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

[rtl/core/base64_stream_decoder_core.sv]
// ============================================================================
// base64_stream_decoder_core
// Base64 decoder: one encoded character in, zero to three bytes out.
// ============================================================================
//
//   channel   handshake          payload
//   --------  -----------------  ------------------------------------------
//   input     push / full        i_in_data  (code_char, final_char)
//   result    pop / empty        o_out_data (data_byte, run_last, string_end)
//
// A character is decoded in the cycle it is accepted; its bytes can be popped
// from the next cycle on. Up to one character and one byte move per cycle.
// The back end emits one byte per cycle while pop is high, so a complete group holds
// its queue entry until all three of its bytes are popped; full rises when QDEPTH bundles are waiting.
// Synchronous reset clears decoder state and empties the queue.
// ============================================================================
module base64_stream_decoder_core #(
    parameter int QDEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  b64d_pkg::t_in_word  i_in_data,
    output logic                empty,
    input  logic                pop,
    output b64d_pkg::t_out_word o_out_data
);
    import b64d_pkg::*;

    t_q_write q_wr;
    t_bundle  q_head;
    logic     q_full, q_empty, q_pop;
    logic     take;

    assign full = q_full;
    assign take = push && !q_full;

    b64d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_in    (i_in_data),
        .o_wr    (q_wr)
    );

    b64d_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_rd    (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    b64d_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_out     (o_out_data)
    );

endmodule

[rtl/core/b64d_queue.sv]
// ============================================================================
// b64d_queue
// Short first-in first-out queue of byte bundles between front and back.
// ============================================================================
module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  b64d_pkg::t_q_write i_wr,
    input  logic              i_rd,
    output b64d_pkg::t_bundle o_head,
    output logic              o_full,
    output logic              o_empty
);
    import b64d_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_bundle       r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          wr_en, rd_en;

    assign wr_en   = i_wr.valid && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Advance pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store bundle payload
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr.bundle;
        end
    end

endmodule

[rtl/core/b64d_front.sv]
// ============================================================================
// b64d_front
// Classifies each character, collects sextets and forms the byte bundle.
// ============================================================================
module b64d_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  b64d_pkg::t_in_word i_in,
    output b64d_pkg::t_q_write o_wr
);
    import b64d_pkg::*;

    logic [17:0] r_store, n_store;
    logic [1:0]  r_count, n_count;
    logic        r_halted, n_halted;
    t_sextet     dec;
    logic [23:0] full_grp;
    t_bundle     bnd;

    assign dec      = sextet_of(i_in.code_char);
    assign full_grp = {r_store, dec.val};

    // Decode one character, halt on one outside the alphabet and flush on the final one
    always_comb begin
        n_store  = r_store;
        n_count  = r_count;
        n_halted = r_halted;
        bnd      = '0;
        if (!r_halted) begin
            if (!dec.ok) begin
                n_halted = 1'b1;
            end else if (r_count == CNT_THREE) begin
                bnd.byte0 = full_grp[23:16];
                bnd.byte1 = full_grp[15:8];
                bnd.byte2 = full_grp[7:0];
                bnd.cnt   = CNT_THREE;
                n_store   = '0;
                n_count   = CNT_NONE;
            end else begin
                n_store = {r_store[11:0], dec.val};
                n_count = r_count + 1'b1;
            end
        end
        if (i_in.final_char) begin
            if (n_count == CNT_TWO) begin
                bnd.byte0 = n_store[11:4];
                bnd.cnt   = CNT_ONE;
            end else if (n_count == CNT_THREE) begin
                bnd.byte0 = n_store[17:10];
                bnd.byte1 = n_store[9:2];
                bnd.cnt   = CNT_TWO;
            end
            bnd.string_end = 1'b1;
            n_store        = '0;
            n_count        = CNT_NONE;
            n_halted       = 1'b0;
        end
    end

    assign o_wr.valid  = i_take && (bnd.cnt != CNT_NONE);
    assign o_wr.bundle = bnd;

    // Hold decoder state between accepted characters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store  <= '0;
            r_count  <= CNT_NONE;
            r_halted <= 1'b0;
        end else if (i_take) begin
            r_store  <= n_store;
            r_count  <= n_count;
            r_halted <= n_halted;
        end
    end

endmodule

[rtl/core/b64d_back.sv]
// ============================================================================
// b64d_back
// Splits the queue's head bundle into one output word per byte.
// ============================================================================
module b64d_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  b64d_pkg::t_bundle   i_head,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output b64d_pkg::t_out_word o_out
);
    import b64d_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       last;

    assign o_empty = i_q_empty;
    assign last    = (r_idx == 2'(i_head.cnt - 2'd1));

    // Select the current byte of the head bundle
    always_comb begin
        unique case (r_idx)
            2'd0:    o_out.data_byte = i_head.byte0;
            2'd1:    o_out.data_byte = i_head.byte1;
            default: o_out.data_byte = i_head.byte2;
        endcase
        o_out.run_last   = last;
        o_out.string_end = last && i_head.string_end;
    end

    // Advance through the bundle, drop it after its last byte
    always_comb begin
        n_idx   = r_idx;
        o_q_pop = 1'b0;
        if (i_pop && !i_q_empty) begin
            if (last) begin
                o_q_pop = 1'b1;
                n_idx   = '0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

[rtl/core/b64d_checker.sv]
// ============================================================================
// b64d_checker
// Port-level checks of the base64 decoder, bound to the top level.
// ============================================================================
`include "base64_stream_decoder_core_macros.svh"

module b64d_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input b64d_pkg::t_out_word o_out_data
);
    import b64d_pkg::*;

    // Reset leaves the queue empty and open
    `B64D_ASSERT_RESET(a_reset_clear, !i_rst_n, empty && !full, "reset did not clear queue")

    // A stalled word stays put
    `B64D_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(o_out_data), "stalled word changed")

    // A byte that is not the last of its run is followed by another
    `B64D_ASSERT_NEXT(a_run_cont, !empty && pop && !o_out_data.run_last, !empty, "run broken")

    // The end of a string closes a run
    `B64D_ASSERT_NOW(a_end_last, !empty && o_out_data.string_end, o_out_data.run_last, "string end mid-run")

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_data (o_out_data)
);
